>>> design/window_stability_detector_assert.svh
// Assertion macros used by the top-level RTL of the window stability detector.
// Each macro checks one implication on the rising clock edge, outside reset.
`ifndef WINDOW_STABILITY_DETECTOR_ASSERT_SVH
`define WINDOW_STABILITY_DETECTOR_ASSERT_SVH

// Same-cycle implication.
`define WSD_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define WSD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/wsd_pkg.sv
`timescale 1ns / 1ps

package wsd_pkg;

    localparam int SAMPLE_W = 24;
    localparam int FILL_W   = 6;
    localparam logic [SAMPLE_W-1:0] TOL_RESET = 24'd800;

    localparam logic ACTION_PUSH  = 1'b0;
    localparam logic ACTION_CLEAR = 1'b1;

    typedef struct packed {
        logic                       action;
        logic signed [SAMPLE_W-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic                       stable;
        logic signed [SAMPLE_W-1:0] mean_value;
        logic [FILL_W-1:0]          fill_count;
        logic                       empty_flag;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_LAUNCH,
        ST_WAIT,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic clear;
        logic update;
        logic scan_start;
        logic div_start;
        logic load_out;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic scan_busy;
        logic div_busy;
    } dp_status_t;

endpackage

>>> design/window_stability_detector.sv
// Timing: a clear goes from its transfer straight to the output register; for a push the
// one-port scan of the sample ring sets the time when the window is full, and the
// bit-serial divider sets it otherwise.
// One item at a time: a new item is taken only after the last result is loaded out.
// Reset: rst_n clears the window, the control state and the output valid at once;
// the tolerance returns to 800 and the ring contents stay undefined until written.
`timescale 1ns / 1ps
`include "window_stability_detector_assert.svh"

module window_stability_detector
    import wsd_pkg::*;
#(
    parameter int WINDOW = 50
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  in_item_t            in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output out_item_t           out_data,
    input  logic                cfg_we,
    input  logic [SAMPLE_W-1:0] cfg_wdata
);

    // The fill count that a full window reports, after the 6-bit masking of the field.
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(WINDOW);

    ctrl_cmd_t  cmd;
    dp_status_t status;
    state_t     state;

    // The controller sequences each push: read the slot about to be overwritten,
    // update the ring, count and running sum, then run the mean division and, on a
    // full window, the min/max scan side by side, and finally load the output register
    // once the previous result has left it. A new input transfer is taken while a result
    // still waits on the output side. A clear goes straight to the output load.
    wsd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (in_data.action),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd),
        .state     (state)
    );

    // The datapath holds the sample ring as a memory with a registered read port,
    // the running sum, the scan unit and the divider.
    wsd_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_data  (out_data)
    );

    // A stable result can only come from a full window.
    `WSD_ASSERT_NOW(a_stable_full, out_valid && out_data.stable,
        out_data.fill_count == FULL_FILL, "stable reported on a window that is not full")

    // An empty window reports a zero mean and is never stable.
    `WSD_ASSERT_NOW(a_empty_result, out_valid && out_data.empty_flag,
        out_data.mean_value == '0 && !out_data.stable && out_data.fill_count == '0,
        "empty window result is inconsistent")

    // Only one item is in work at a time.
    `WSD_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready,
        "input taken while an item is in work")

    // The scan and the divider only run while the controller waits for them.
    `WSD_ASSERT_NOW(a_units_idle, status.scan_busy || status.div_busy,
        state == ST_WAIT, "scan or divide active outside the wait state")

endmodule

>>> design/wsd_divider.sv
`timescale 1ns / 1ps

module wsd_divider
    import wsd_pkg::*;
#(
    parameter int SUM_W = 30,
    parameter int CNT_W = 6
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [SUM_W-1:0]    dividend,
    input  logic [CNT_W-1:0]           divisor,
    output logic                       busy,
    output logic signed [SAMPLE_W-1:0] quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              busy_reg, busy_next;
    logic              neg_reg;
    logic [SUM_W-1:0]  dvd_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  dsr_reg;
    logic [STEP_W-1:0] step_reg;

    logic [CNT_W:0]        trial;
    logic [CNT_W-1:0]      diff;
    logic                  ge;
    logic [SAMPLE_W-1:0]   q_mag;

    // One restoring step per cycle on the magnitude; the sign is applied at the end.
    // When the trial value reaches the divisor the difference is below the divisor,
    // so it fits the remainder width.
    assign trial = {rem_reg, dvd_reg[SUM_W-1]};
    assign diff  = trial[CNT_W-1:0] - dsr_reg;
    assign ge    = (trial >= {1'b0, dsr_reg});
    assign q_mag = dvd_reg[SAMPLE_W-1:0];

    always_comb
    begin
        busy_next = busy_reg;
        if (start)
        begin
            busy_next = 1'b1;
        end
        else if (busy_reg && (step_reg == STEP_W'(1)))
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg  <= dividend[SUM_W-1];
            dvd_reg  <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
            rem_reg  <= '0;
            dsr_reg  <= divisor;
            step_reg <= STEP_W'(SUM_W);
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff : trial[CNT_W-1:0];
            dvd_reg  <= {dvd_reg[SUM_W-2:0], ge};
            step_reg <= step_reg - STEP_W'(1);
        end
    end

    assign busy     = busy_reg;
    assign quotient = neg_reg ? SAMPLE_W'(-q_mag) : q_mag;

endmodule

>>> design/wsd_datapath.sv
`timescale 1ns / 1ps

module wsd_datapath
    import wsd_pkg::*;
#(
    parameter int WINDOW = 50
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_cmd_t           cmd,
    output dp_status_t          status,
    input  in_item_t            in_data,
    input  logic                cfg_we,
    input  logic [SAMPLE_W-1:0] cfg_wdata,
    output out_item_t           out_data
);

    localparam int PTR_W = $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = SAMPLE_W + CNT_W;

    logic signed [SAMPLE_W-1:0] ring [WINDOW];

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [PTR_W-1:0]           wp_reg;
    logic [CNT_W-1:0]           count_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic [SAMPLE_W-1:0]        tol_reg;
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic [PTR_W-1:0]           scan_idx_reg;
    logic                       scan_issue_reg;
    logic                       scan_vld_reg;
    logic                       scan_first_reg;
    logic signed [SAMPLE_W-1:0] min_reg;
    logic signed [SAMPLE_W-1:0] max_reg;
    out_item_t                  out_data_reg;

    logic [PTR_W-1:0]           rd_addr;
    logic                       full;
    logic signed [SUM_W-1:0]    sum_next;
    logic signed [SAMPLE_W:0]   spread;
    logic                       div_busy;
    logic signed [SAMPLE_W-1:0] quotient;

    assign full     = (count_reg == CNT_W'(WINDOW));
    assign rd_addr  = scan_issue_reg ? scan_idx_reg : wp_reg;
    assign sum_next = sum_reg + SUM_W'(sample_reg)
                    - (full ? SUM_W'(rd_data_reg) : SUM_W'(0));
    assign spread   = {max_reg[SAMPLE_W-1], max_reg} - {min_reg[SAMPLE_W-1], min_reg};

    always_ff @(posedge clk)
    begin
        rd_data_reg <= ring[rd_addr];
        if (cmd.update)
        begin
            ring[wp_reg] <= sample_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg         <= '0;
            count_reg      <= '0;
            sum_reg        <= '0;
            tol_reg        <= TOL_RESET;
            scan_issue_reg <= 1'b0;
            scan_vld_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                tol_reg <= cfg_wdata;
            end
            if (cmd.clear)
            begin
                wp_reg    <= '0;
                count_reg <= '0;
                sum_reg   <= '0;
            end
            else if (cmd.update)
            begin
                sum_reg <= sum_next;
                wp_reg  <= (wp_reg == PTR_W'(WINDOW - 1)) ? '0 : wp_reg + PTR_W'(1);
                if (!full)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            if (cmd.scan_start)
            begin
                scan_issue_reg <= 1'b1;
            end
            else if (scan_issue_reg && (scan_idx_reg == PTR_W'(WINDOW - 1)))
            begin
                scan_issue_reg <= 1'b0;
            end
            scan_vld_reg <= scan_issue_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= in_data.sample;
        end
        if (cmd.scan_start)
        begin
            scan_idx_reg   <= '0;
            scan_first_reg <= 1'b1;
        end
        else
        begin
            if (scan_issue_reg)
            begin
                scan_idx_reg <= scan_idx_reg + PTR_W'(1);
            end
            if (scan_vld_reg)
            begin
                scan_first_reg <= 1'b0;
                if (scan_first_reg || (rd_data_reg < min_reg))
                begin
                    min_reg <= rd_data_reg;
                end
                if (scan_first_reg || (rd_data_reg > max_reg))
                begin
                    max_reg <= rd_data_reg;
                end
            end
        end
        if (cmd.load_out)
        begin
            out_data_reg.stable     <= full && ($unsigned(spread) < {1'b0, tol_reg});
            out_data_reg.mean_value <= (count_reg == '0) ? '0 : quotient;
            out_data_reg.fill_count <= FILL_W'(count_reg);
            out_data_reg.empty_flag <= (count_reg == '0);
        end
    end

    wsd_divider #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign status.full      = full;
    assign status.scan_busy = scan_issue_reg | scan_vld_reg;
    assign status.div_busy  = div_busy;
    assign out_data         = out_data_reg;

endmodule

>>> design/wsd_ctrl.sv
`timescale 1ns / 1ps

module wsd_ctrl
    import wsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       action,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd,
    output state_t     state
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    cmd.clear   = (action == ACTION_CLEAR);
                    state_next  = (action == ACTION_CLEAR) ? ST_FINISH : ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_LAUNCH;
            end
            ST_LAUNCH:
            begin
                cmd.scan_start = status.full;
                cmd.div_start  = 1'b1;
                state_next     = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (!status.scan_busy && !status.div_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign state     = state_reg;

endmodule

>>> tb/sv/window_stability_detector_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the sliding-window stability detector.
// Each accepted input transfer is run through a software copy of the window.
// That copy yields the one result the transfer must cause. Output transfers
// are compared field by field against the oldest queued prediction.
module window_stability_detector_tb;
    import wsd_pkg::*;

    localparam int WINDOW = 50;
    localparam int QUIET_LIMIT = 3000;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 200;
    localparam longint SAMPLE_MAX = 64'sd8388607;

    // Scoreboard: a copy of the sample ring, pointer, fill count and running sum.
    // It turns every accepted input into the result the block should produce.
    class stability_scoreboard;
        logic signed [SAMPLE_W-1:0] ring [WINDOW];
        int unsigned                wr_slot;
        int unsigned                held;
        longint                     window_sum;
        logic [SAMPLE_W-1:0]        tolerance;
        out_item_t                  expected_results[$];
        int unsigned                errors;

        function new();
            wr_slot = 0;
            held = 0;
            window_sum = 0;
            tolerance = TOL_RESET;
            errors = 0;
        endfunction

        function void set_tolerance(logic [SAMPLE_W-1:0] value);
            tolerance = value;
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        function void note_transfer(in_item_t item);
            out_item_t res;
            int        lo;
            int        hi;
            longint    mean;
            if (item.action == ACTION_CLEAR)
            begin
                wr_slot = 0;
                held = 0;
                window_sum = 0;
            end
            else
            begin
                // A full window drops its oldest sample, which sits in the slot
                // about to be overwritten.
                if (held >= WINDOW)
                    window_sum -= ring[wr_slot];
                else
                    held++;
                ring[wr_slot] = item.sample;
                window_sum += $signed(item.sample);
                wr_slot = (wr_slot + 1) % WINDOW;
            end
            mean = 0;
            if (held > 0)
                mean = window_sum / longint'(held);
            res.stable = 1'b0;
            if (held >= WINDOW)
            begin
                lo = int'(ring[0]);
                hi = int'(ring[0]);
                for (int i = 1; i < WINDOW; i++)
                begin
                    if (ring[i] < lo)
                        lo = int'(ring[i]);
                    if (ring[i] > hi)
                        hi = int'(ring[i]);
                end
                res.stable = (longint'(hi) - longint'(lo)) < longint'(tolerance);
            end
            res.mean_value = mean[SAMPLE_W-1:0];
            res.fill_count = held[FILL_W-1:0];
            res.empty_flag = (held == 0);
            expected_results = {expected_results, res};
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result with no prediction pending: %p", $realtime, got);
                return;
            end
            want = expected_results.pop_front();
            if (got.stable !== want.stable || got.mean_value !== want.mean_value ||
                got.fill_count !== want.fill_count || got.empty_flag !== want.empty_flag)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: mismatch: expected %p, got %p", $realtime, want, got);
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    logic      cfg_we;
    logic [SAMPLE_W-1:0] cfg_wdata;

    stability_scoreboard sb;
    int unsigned quiet_cycles;
    // While a burst flag is set that side runs without idle cycles.
    bit          tx_burst;
    bit          rx_burst;

    window_stability_detector #(
        .WINDOW(WINDOW)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: a run that stops moving transfers in either direction for far
    // longer than one slow item, with maximum idling on both sides, is hung.
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("** window_stability_detector: FAILED **");
                $finish;
            end
        end
    end

    function automatic in_item_t make_item(logic action, logic [SAMPLE_W-1:0] sample);
        in_item_t item;
        item.action = action;
        item.sample = sample;
        return item;
    endfunction

    // Offers one item after a random gap and returns at the edge of its transfer.
    // Valid stays high when the next item follows with no gap, so it is never
    // dropped and raised in the same time step.
    task automatic send_item(input in_item_t item);
        int unsigned gap;
        if ($urandom_range(0, 49) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 17);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_transfer(item);
    endtask

    // Drops valid and waits until every predicted result has come back, plus a
    // few cycles so that the block is idle before the tolerance changes.
    task automatic drain_block();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_tolerance(input logic [SAMPLE_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_tolerance(value);
    endtask

    // Random traffic for one tolerance setting. Most of it is well-formed fill
    // runs: an optional clear, then WINDOW - 3 to WINDOW + 40 pushes that mostly
    // fill and roll the window, clustered around a base value with a chosen amplitude
    // so that the spread lands below, near and above the tolerance. Rare spikes knock a
    // settled window out of tolerance. The rest is raw noise with random actions.
    task automatic random_phase(input int unsigned budget);
        int unsigned sent;
        int unsigned run_len;
        int unsigned amp;
        bit          full_range;
        int          base;
        longint      value;
        logic signed [SAMPLE_W-1:0] raw;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(0, 99) < 78)
            begin
                if ($urandom_range(0, 4) != 0)
                begin
                    send_item(make_item(ACTION_CLEAR, SAMPLE_W'($urandom)));
                    sent++;
                end
                raw = SAMPLE_W'($urandom);
                base = int'(raw);
                full_range = 1'b0;
                case ($urandom_range(0, 4))
                    0: amp = 0;
                    1: amp = $urandom_range(0, 1000);
                    2: amp = $urandom_range(0, sb.tolerance + sb.tolerance / 4 + 2);
                    3: amp = $urandom_range(0, 200000);
                    default:
                    begin
                        amp = 0;
                        full_range = 1'b1;
                    end
                endcase
                run_len = $urandom_range(WINDOW - 3, WINDOW + 40);
                repeat (run_len)
                begin
                    if (full_range || $urandom_range(0, 39) == 0)
                        raw = SAMPLE_W'($urandom);
                    else
                    begin
                        value = longint'(base) + longint'($urandom_range(0, amp));
                        if (value > SAMPLE_MAX)
                            value = SAMPLE_MAX;
                        raw = value[SAMPLE_W-1:0];
                    end
                    send_item(make_item(ACTION_PUSH, raw));
                    sent++;
                end
            end
            else
            begin
                repeat ($urandom_range(1, 20))
                begin
                    send_item(make_item(($urandom_range(0, 3) == 0) ? ACTION_CLEAR : ACTION_PUSH,
                                        SAMPLE_W'($urandom)));
                    sent++;
                end
            end
        end
    endtask

    // Result side: random stalls on ready, with stall-free stretches.
    initial
    begin
        int unsigned stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 49) == 0)
                rx_burst = !rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 17);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            sb.check_result(out_data);
        end
    end

    initial
    begin
        logic [SAMPLE_W-1:0] tol;
        sb = new();
        tx_burst = 1'b0;
        rx_burst = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset tolerance. It covers a clear of an empty
        // window, the sample extremes, and mean truncation toward zero for
        // negative sums. It also covers a clear whose ignored sample is
        // nonzero, and alternating bit patterns.
        send_item(make_item(ACTION_CLEAR, 24'h7FFFFF));
        send_item(make_item(ACTION_PUSH, 24'h7FFFFF));
        send_item(make_item(ACTION_PUSH, 24'h800000));
        send_item(make_item(ACTION_PUSH, 24'h800000));
        send_item(make_item(ACTION_PUSH, 24'hFFFFFF));
        send_item(make_item(ACTION_CLEAR, 24'h800000));
        send_item(make_item(ACTION_PUSH, 24'hFFFFFF));
        send_item(make_item(ACTION_PUSH, 24'h000001));
        send_item(make_item(ACTION_PUSH, 24'hFFFFFD));
        send_item(make_item(ACTION_PUSH, 24'h000002));
        send_item(make_item(ACTION_CLEAR, 24'h000000));
        send_item(make_item(ACTION_CLEAR, 24'hFFFFFF));
        send_item(make_item(ACTION_PUSH, 24'h000000));
        send_item(make_item(ACTION_PUSH, 24'h555555));
        send_item(make_item(ACTION_PUSH, 24'hAAAAAA));
        send_item(make_item(ACTION_CLEAR, 24'h555555));
        drain_block();

        // One phase per tolerance. The set includes zero, where nothing can be
        // stable, the full-scale maximum, one, and the reset value.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: tol = '0;
                1: tol = '1;
                2: tol = 24'd1;
                3: tol = TOL_RESET;
                4: tol = SAMPLE_W'($urandom_range(1, 3000));
                5: tol = SAMPLE_W'($urandom);
                6: tol = SAMPLE_W'($urandom_range(0, 600));
                default: tol = 24'hFFFFFE;
            endcase
            write_tolerance(tol);
            random_phase(PHASE_ITEMS);
            drain_block();
        end

        // Extra cycles catch any stray result after the last prediction.
        repeat (WINDOW + 20) @(posedge clk);
        sb.errors += sb.pending();
        if (sb.errors == 0)
            $display("** window_stability_detector: PASSED **");
        else
            $display("** window_stability_detector: FAILED **");
        $finish;
    end

endmodule
